>>> hdl/ptpg_pkg.sv
// ----------------------------------------------------------------------------
// Pendulum tip position generator package
// Shared constants, types and arithmetic helpers for the tip generator.
// ----------------------------------------------------------------------------
`default_nettype none

package ptpg_pkg;

   localparam int CORD_W = 34;

   typedef logic signed [CORD_W-1:0] cord_type;
   typedef logic signed [31:0]       unit_type;

   localparam cord_type Q30_ONE     = 34'sd1073741824;
   localparam cord_type Q30_HALFPI  = 34'sd1686629713;
   localparam cord_type Q30_PI      = 34'sd3373259426;
   localparam cord_type CORDIC_GAIN = 34'sd652032875;

   localparam unit_type UNIT_POS = 32'sd1073741824;
   localparam unit_type UNIT_NEG = -32'sd1073741824;

   localparam logic signed [31:0] INV_TWO_PI_Q32 = 32'sd683565276;
   localparam logic signed [31:0] HALFPI_Q30     = 32'sd1686629713;

   localparam logic [15:0] LEN_ONE = 16'd16;

   localparam logic signed [47:0] TIP_ROUND = 48'sd33554432;
   localparam logic signed [24:0] TIP_MAX   = 25'sd8388607;
   localparam logic signed [24:0] TIP_MIN   = -25'sd8388608;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] REG_ANCHOR_X        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ANCHOR_Y        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ARM_LENGTH      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SWING_AMPLITUDE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ANGULAR_SPEED   = 3'd4;

   localparam logic [15:0]        ARM_LENGTH_RESET      = 16'd3200;
   localparam logic signed [15:0] SWING_AMPLITUDE_RESET = 16'sd9830;
   localparam logic signed [15:0] ANGULAR_SPEED_RESET   = 16'sd768;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_SPD,
      ST_MUL_INV,
      ST_PHASE,
      ST_MUL_RAD,
      ST_ROT_LOAD,
      ST_ROT_RUN,
      ST_ROT_DONE,
      ST_MUL_AMP,
      ST_MUL_X,
      ST_MUL_Y,
      ST_TIP_Y
   } state_type;

   function automatic cord_type atan_q30(input logic [4:0] idx);
      cord_type r;
      unique case (idx)
         5'd0:    r = 34'sd843314857;
         5'd1:    r = 34'sd497837829;
         5'd2:    r = 34'sd263043837;
         5'd3:    r = 34'sd133525159;
         5'd4:    r = 34'sd67021687;
         5'd5:    r = 34'sd33543516;
         5'd6:    r = 34'sd16775851;
         5'd7:    r = 34'sd8388437;
         5'd8:    r = 34'sd4194283;
         5'd9:    r = 34'sd2097149;
         5'd10:   r = 34'sd1048575;
         5'd11:   r = 34'sd524288;
         5'd12:   r = 34'sd262144;
         5'd13:   r = 34'sd131072;
         5'd14:   r = 34'sd65536;
         5'd15:   r = 34'sd32768;
         5'd16:   r = 34'sd16384;
         5'd17:   r = 34'sd8192;
         5'd18:   r = 34'sd4096;
         5'd19:   r = 34'sd2048;
         5'd20:   r = 34'sd1024;
         5'd21:   r = 34'sd512;
         5'd22:   r = 34'sd256;
         5'd23:   r = 34'sd128;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic unit_type clamp_unit(input cord_type v);
      unit_type r;
      if (v > Q30_ONE) begin
         r = UNIT_POS;
      end else if (v < -Q30_ONE) begin
         r = UNIT_NEG;
      end else begin
         r = signed'(v[31:0]);
      end
      return r;
   endfunction

   function automatic logic signed [23:0] tip_coord(input logic signed [23:0] anchor,
                                                    input logic signed [47:0] prod);
      logic signed [47:0] rnd;
      logic signed [21:0] off;
      logic signed [24:0] sum;
      logic signed [23:0] r;
      rnd = prod + TIP_ROUND;
      off = signed'(rnd[47:26]);
      sum = 25'(anchor) + 25'(off);
      if (sum > TIP_MAX) begin
         r = TIP_MAX[23:0];
      end else if (sum < TIP_MIN) begin
         r = TIP_MIN[23:0];
      end else begin
         r = sum[23:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hdl/ptpg_if.sv
// ----------------------------------------------------------------------------
// Pendulum tip position generator channels
// Valid/ready interfaces for the request, response and register channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptpg_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] time_step;
   logic        restart;

   modport source (output valid, output time_step, output restart, input ready);
   modport sink   (input valid, input time_step, input restart, output ready);
endinterface

interface ptpg_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] tip_x;
   logic signed [23:0] tip_y;

   modport source (output valid, output tip_x, output tip_y, input ready);
   modport sink   (input valid, input tip_x, input tip_y, output ready);
endinterface

interface ptpg_csr_if;
   logic                               valid;
   logic                               ready;
   logic [ptpg_pkg::CSR_INDEX_W-1:0]   index;
   logic [ptpg_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/pendulum_tip_position_generator.sv
// ----------------------------------------------------------------------------
// Pendulum tip position generator
// Accumulates a swing phase per time step and returns the pendulum tip
// position from two CORDIC sine/cosine passes and one shared multiplier.
// ----------------------------------------------------------------------------
//
//  Channel   Role    Payload                      Transfer
//  req_chan  sink    time_step[15:0], restart     valid & ready
//  rsp_chan  source  tip_x[23:0], tip_y[23:0]     valid & ready
//  csr_chan  sink    index[2:0], data[23:0]       valid & ready (ready always 1)
//
//  Items do not overlap: a request transfers only in the idle state, and the single
//  CORDIC stage is used twice per item, once for the phase sine and once for the angle.
//  The result lands in the output register on the edge that returns the generator
//  to idle, where the next request can transfer.
//  Synchronous reset returns the registers to their reset values and the phase to 0.
//  A result waiting on rsp_chan does not block a new request; a second result
//  waits in the last step until the output register is free.
//
`default_nettype none

module pendulum_tip_position_generator #(
   parameter int PHASE_BITS   = 24,
   parameter int CORDIC_STEPS = 16
) (
   input  wire              clock,
   input  wire              reset,
   ptpg_req_if.sink         req_chan,
   ptpg_rsp_if.source       rsp_chan,
   ptpg_csr_if.sink         csr_chan
);

   ptpg_pkg::state_type state_ff, state_in;

   logic signed [23:0] anchor_x_ff;
   logic signed [23:0] anchor_y_ff;
   logic [15:0]        arm_length_ff;
   logic signed [15:0] swing_amplitude_ff;
   logic signed [15:0] angular_speed_ff;

   logic [PHASE_BITS-1:0] phase_ff;
   logic [15:0]           dt_ff;
   logic                  pass_ff;

   logic signed [63:0] mul_ff;
   logic signed [31:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [63:0] mul_prod;
   logic               mul_en;

   ptpg_pkg::cord_type x_ff, y_ff, z_ff;
   logic               neg_ff;
   logic [4:0]         iter_ff;

   ptpg_pkg::unit_type sp_ff, sa_ff, ca_ff;
   logic signed [23:0] tipx_ff;

   logic               rsp_valid_ff;
   logic signed [23:0] rsp_tip_x_ff;
   logic signed [23:0] rsp_tip_y_ff;

   logic               req_ready;
   logic               req_fire;
   logic               out_free;
   logic               out_load;

   logic [15:0]        len_eff;
   logic signed [31:0] turn;
   ptpg_pkg::cord_type rot_src;
   ptpg_pkg::cord_type x_sh, y_sh, atan_val;
   ptpg_pkg::unit_type sin_c, cos_c;

   assign req_chan.ready = req_ready;
   assign req_fire       = req_chan.valid && req_ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.tip_x = rsp_tip_x_ff;
   assign rsp_chan.tip_y = rsp_tip_y_ff;
   assign csr_chan.ready = 1'b1;

   assign len_eff  = (arm_length_ff == '0) ? ptpg_pkg::LEN_ONE : arm_length_ff;
   assign turn     = signed'(32'(phase_ff) << (32 - PHASE_BITS));
   assign rot_src  = pass_ff ? 34'(signed'(mul_ff[46:14])) : 34'(signed'(mul_ff[62:30]));
   assign x_sh     = x_ff >>> iter_ff;
   assign y_sh     = y_ff >>> iter_ff;
   assign atan_val = ptpg_pkg::atan_q30(iter_ff);
   assign sin_c    = neg_ff ? -ptpg_pkg::clamp_unit(y_ff) : ptpg_pkg::clamp_unit(y_ff);
   assign cos_c    = neg_ff ? -ptpg_pkg::clamp_unit(x_ff) : ptpg_pkg::clamp_unit(x_ff);
   assign mul_prod = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptpg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      mul_en    = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      out_load  = 1'b0;
      unique case (state_ff)
         ptpg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_chan.valid) begin
               state_in = ptpg_pkg::ST_MUL_SPD;
            end
         end
         ptpg_pkg::ST_MUL_SPD: begin
            mul_en   = 1'b1;
            mul_a    = 32'(angular_speed_ff);
            mul_b    = {16'd0, dt_ff};
            state_in = ptpg_pkg::ST_MUL_INV;
         end
         ptpg_pkg::ST_MUL_INV: begin
            mul_en   = 1'b1;
            mul_a    = mul_ff[31:0];
            mul_b    = ptpg_pkg::INV_TWO_PI_Q32;
            state_in = ptpg_pkg::ST_PHASE;
         end
         ptpg_pkg::ST_PHASE: begin
            state_in = ptpg_pkg::ST_MUL_RAD;
         end
         ptpg_pkg::ST_MUL_RAD: begin
            mul_en   = 1'b1;
            mul_a    = turn;
            mul_b    = ptpg_pkg::HALFPI_Q30;
            state_in = ptpg_pkg::ST_ROT_LOAD;
         end
         ptpg_pkg::ST_ROT_LOAD: begin
            state_in = ptpg_pkg::ST_ROT_RUN;
         end
         ptpg_pkg::ST_ROT_RUN: begin
            if (iter_ff == 5'(CORDIC_STEPS - 1)) begin
               state_in = ptpg_pkg::ST_ROT_DONE;
            end
         end
         ptpg_pkg::ST_ROT_DONE: begin
            state_in = pass_ff ? ptpg_pkg::ST_MUL_X : ptpg_pkg::ST_MUL_AMP;
         end
         ptpg_pkg::ST_MUL_AMP: begin
            mul_en   = 1'b1;
            mul_a    = 32'(swing_amplitude_ff);
            mul_b    = sp_ff;
            state_in = ptpg_pkg::ST_ROT_LOAD;
         end
         ptpg_pkg::ST_MUL_X: begin
            mul_en   = 1'b1;
            mul_a    = {16'd0, len_eff};
            mul_b    = sa_ff;
            state_in = ptpg_pkg::ST_MUL_Y;
         end
         ptpg_pkg::ST_MUL_Y: begin
            mul_en   = 1'b1;
            mul_a    = {16'd0, len_eff};
            mul_b    = ca_ff;
            state_in = ptpg_pkg::ST_TIP_Y;
         end
         ptpg_pkg::ST_TIP_Y: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ptpg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ptpg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         anchor_x_ff        <= '0;
         anchor_y_ff        <= '0;
         arm_length_ff      <= ptpg_pkg::ARM_LENGTH_RESET;
         swing_amplitude_ff <= ptpg_pkg::SWING_AMPLITUDE_RESET;
         angular_speed_ff   <= ptpg_pkg::ANGULAR_SPEED_RESET;
         phase_ff           <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            unique case (csr_chan.index)
               ptpg_pkg::REG_ANCHOR_X:        anchor_x_ff        <= signed'(csr_chan.data);
               ptpg_pkg::REG_ANCHOR_Y:        anchor_y_ff        <= signed'(csr_chan.data);
               ptpg_pkg::REG_ARM_LENGTH:      arm_length_ff      <= csr_chan.data[15:0];
               ptpg_pkg::REG_SWING_AMPLITUDE: swing_amplitude_ff <= signed'(csr_chan.data[15:0]);
               ptpg_pkg::REG_ANGULAR_SPEED:   angular_speed_ff   <= signed'(csr_chan.data[15:0]);
               default: ;
            endcase
         end
         if (req_fire && req_chan.restart) begin
            phase_ff <= '0;
         end else if (state_ff == ptpg_pkg::ST_PHASE) begin
            phase_ff <= phase_ff + mul_ff[56-PHASE_BITS +: PHASE_BITS];
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         dt_ff <= req_chan.time_step;
      end
      if (mul_en) begin
         mul_ff <= mul_prod;
      end
      unique case (state_ff)
         ptpg_pkg::ST_MUL_RAD: begin
            pass_ff <= 1'b0;
         end
         ptpg_pkg::ST_MUL_AMP: begin
            pass_ff <= 1'b1;
         end
         ptpg_pkg::ST_ROT_LOAD: begin
            x_ff    <= ptpg_pkg::CORDIC_GAIN;
            y_ff    <= '0;
            iter_ff <= '0;
            if (rot_src > ptpg_pkg::Q30_HALFPI) begin
               z_ff   <= rot_src - ptpg_pkg::Q30_PI;
               neg_ff <= 1'b1;
            end else if (rot_src < -ptpg_pkg::Q30_HALFPI) begin
               z_ff   <= rot_src + ptpg_pkg::Q30_PI;
               neg_ff <= 1'b1;
            end else begin
               z_ff   <= rot_src;
               neg_ff <= 1'b0;
            end
         end
         ptpg_pkg::ST_ROT_RUN: begin
            iter_ff <= iter_ff + 5'd1;
            if (!z_ff[ptpg_pkg::CORD_W-1]) begin
               x_ff <= x_ff - y_sh;
               y_ff <= y_ff + x_sh;
               z_ff <= z_ff - atan_val;
            end else begin
               x_ff <= x_ff + y_sh;
               y_ff <= y_ff - x_sh;
               z_ff <= z_ff + atan_val;
            end
         end
         ptpg_pkg::ST_ROT_DONE: begin
            if (pass_ff) begin
               sa_ff <= sin_c;
               ca_ff <= cos_c;
            end else begin
               sp_ff <= sin_c;
            end
         end
         ptpg_pkg::ST_MUL_Y: begin
            tipx_ff <= ptpg_pkg::tip_coord(anchor_x_ff, mul_ff[47:0]);
         end
         default: ;
      endcase
      if (out_load) begin
         rsp_tip_x_ff <= tipx_ff;
         rsp_tip_y_ff <= ptpg_pkg::tip_coord(anchor_y_ff, mul_ff[47:0]);
      end
   end

   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_chan.ready)
      else $error("request taken while an item is still in work");

   a_result_from_last_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ptpg_pkg::ST_TIP_Y)
      else $error("response raised outside the final step");

   a_iter_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ptpg_pkg::ST_ROT_RUN |-> iter_ff < 5'(CORDIC_STEPS))
      else $error("rotation step count out of range");

   a_sine_clamped: assert property (@(posedge clock) disable iff (reset)
      state_ff == ptpg_pkg::ST_MUL_AMP |->
         (sp_ff <= ptpg_pkg::UNIT_POS && sp_ff >= ptpg_pkg::UNIT_NEG))
      else $error("phase sine outside the unit range");

endmodule

`default_nettype wire
